/* hdl/npcs_pkg.sv */
// ----------------------------------------------------------------------------
// npcs_pkg: shared types and constants for the nearest palette colour search
// Widths, luminance weights, request codes and the structs that travel
// between the sequencer, the palette memory and the distance unit.
// ----------------------------------------------------------------------------
package npcs_pkg;

   // Palette geometry
   localparam int PALETTE_ENTRIES = 256;
   localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
   localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);

   // Fixed field widths
   localparam int COMP_W   = 8;
   localparam int ENTRY_W  = 8;
   localparam int COLOUR_W = 8;

   // Key widths
   localparam int SQ_W   = 2 * COMP_W;
   localparam int WSUM_W = SQ_W + 8;
   localparam int PRIM_W = WSUM_W - 5;
   localparam int BOX_W  = COMP_W + 2;
   localparam int LSUM_W = COMP_W + 8;
   localparam int LUM_W  = COMP_W;

   // Luminance weights, also used by the weighted metric
   localparam logic [7:0] LUMA_R = 8'd77;
   localparam logic [7:0] LUMA_G = 8'd151;
   localparam logic [7:0] LUMA_B = 8'd28;

   // Request codes
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Metric codes
   localparam logic METRIC_PLAIN    = 1'b0;
   localparam logic METRIC_WEIGHTED = 1'b1;

   typedef struct packed {
      logic [COMP_W-1:0] r;
      logic [COMP_W-1:0] g;
      logic [COMP_W-1:0] b;
   } rgb_type;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [IDX_W-1:0] idx;
   } tag_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      rgb_type          rgb;
   } mem_wr_type;

   typedef struct packed {
      tag_type tag;
      rgb_type rgb;
   } palette_rd_type;

   // Packed in priority order so one magnitude compare is lexicographic
   typedef struct packed {
      logic [PRIM_W-1:0] prim;
      logic [BOX_W-1:0]  box;
      logic [LUM_W-1:0]  lum;
   } key_type;

   typedef struct packed {
      tag_type tag;
      key_type key;
   } scan_res_type;

endpackage

/* hdl/npcs_req_if.sv */
// ----------------------------------------------------------------------------
// npcs_req_if: request channel
// Valid/ready channel carrying palette writes and colour queries.
// ----------------------------------------------------------------------------
interface npcs_req_if import npcs_pkg::*; ();

   logic                valid;
   logic                ready;
   logic                req_type;
   logic [ENTRY_W-1:0]  entry_index;
   logic [COMP_W-1:0]   red;
   logic [COMP_W-1:0]   green;
   logic [COMP_W-1:0]   blue;

   modport source (
      output valid, req_type, entry_index, red, green, blue,
      input  ready
   );

   modport sink (
      input  valid, req_type, entry_index, red, green, blue,
      output ready
   );

endinterface

/* hdl/npcs_rsp_if.sv */
// ----------------------------------------------------------------------------
// npcs_rsp_if: response channel
// Valid/ready channel carrying the index of the best palette entry.
// ----------------------------------------------------------------------------
interface npcs_rsp_if import npcs_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [COLOUR_W-1:0] colour_index;

   modport source (
      output valid, colour_index,
      input  ready
   );

   modport sink (
      input  valid, colour_index,
      output ready
   );

endinterface

/* hdl/npcs_palette_mem.sv */
// ----------------------------------------------------------------------------
// npcs_palette_mem: palette storage
// One write port and one registered read port; the scan tag follows the
// read data so the distance unit knows which entry it holds.
// ----------------------------------------------------------------------------
module npcs_palette_mem import npcs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  mem_wr_type     wr,
   input  tag_type        rd_issue,
   output palette_rd_type rd
);

   rgb_type mem [PALETTE_ENTRIES];
   rgb_type rd_rgb_ff;
   tag_type rd_tag_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.rgb;
      end
      rd_rgb_ff <= mem[rd_issue.idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_tag_ff <= '0;
      end else begin
         rd_tag_ff <= rd_issue;
      end
   end

   assign rd.tag = rd_tag_ff;
   assign rd.rgb = rd_rgb_ff;

endmodule

/* hdl/npcs_dist_unit.sv */
// ----------------------------------------------------------------------------
// npcs_dist_unit: shared distance unit
// Three-stage pipeline that turns one palette entry into its search key:
// absolute differences and luminance, then squares and box distance, then
// the primary distance for the selected metric.
// ----------------------------------------------------------------------------
module npcs_dist_unit import npcs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           metric_mode,
   input  rgb_type        query,
   input  palette_rd_type rd,
   output scan_res_type   res
);

   // Stage 1: differences and luminance
   tag_type           s1_tag_ff;
   logic [COMP_W-1:0] s1_dr_ff, s1_dg_ff, s1_db_ff;
   logic [LUM_W-1:0]  s1_lum_ff;
   logic [COMP_W-1:0] s1_dr_in, s1_dg_in, s1_db_in;
   logic [LSUM_W-1:0] lsum;

   // Stage 2: squares and box distance
   tag_type           s2_tag_ff;
   logic [SQ_W-1:0]   s2_sr_ff, s2_sg_ff, s2_sb_ff;
   logic [BOX_W-1:0]  s2_box_ff;
   logic [LUM_W-1:0]  s2_lum_ff;

   // Stage 3: primary distance
   tag_type           s3_tag_ff;
   key_type           s3_key_ff;
   key_type           s3_key_in;
   logic [WSUM_W-1:0] wsum;

   function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                   input logic [COMP_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   always_comb begin
      s1_dr_in = abs_diff(rd.rgb.r, query.r);
      s1_dg_in = abs_diff(rd.rgb.g, query.g);
      s1_db_in = abs_diff(rd.rgb.b, query.b);
      lsum     = LSUM_W'(rd.rgb.r) * LSUM_W'(LUMA_R)
               + LSUM_W'(rd.rgb.g) * LSUM_W'(LUMA_G)
               + LSUM_W'(rd.rgb.b) * LSUM_W'(LUMA_B);
   end

   always_comb begin
      wsum = WSUM_W'(s2_sr_ff) * WSUM_W'(LUMA_R)
           + WSUM_W'(s2_sg_ff) * WSUM_W'(LUMA_G)
           + WSUM_W'(s2_sb_ff) * WSUM_W'(LUMA_B);
      s3_key_in.box = s2_box_ff;
      s3_key_in.lum = s2_lum_ff;
      case (metric_mode)
         METRIC_WEIGHTED: s3_key_in.prim = wsum[WSUM_W-1:5];
         default: s3_key_in.prim = PRIM_W'(s2_sr_ff) + PRIM_W'(s2_sg_ff)
                                 + PRIM_W'(s2_sb_ff);
      endcase
   end

   // Payload stages
   always_ff @(posedge clock) begin
      s1_dr_ff  <= s1_dr_in;
      s1_dg_ff  <= s1_dg_in;
      s1_db_ff  <= s1_db_in;
      s1_lum_ff <= lsum[LSUM_W-1:8];

      s2_sr_ff  <= SQ_W'(s1_dr_ff) * SQ_W'(s1_dr_ff);
      s2_sg_ff  <= SQ_W'(s1_dg_ff) * SQ_W'(s1_dg_ff);
      s2_sb_ff  <= SQ_W'(s1_db_ff) * SQ_W'(s1_db_ff);
      s2_box_ff <= BOX_W'(s1_dr_ff) + BOX_W'(s1_dg_ff) + BOX_W'(s1_db_ff);
      s2_lum_ff <= s1_lum_ff;

      s3_key_ff <= s3_key_in;
   end

   // Tags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
      end else begin
         s1_tag_ff <= rd.tag;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   assign res.tag = s3_tag_ff;
   assign res.key = s3_key_ff;

endmodule

/* hdl/npcs_ctrl.sv */
// ----------------------------------------------------------------------------
// npcs_ctrl: request sequencer and best-match tracker
// Takes requests, writes the palette, walks every entry through the distance
// unit for a query, keeps the running minimum and presents the result.
// ----------------------------------------------------------------------------
module npcs_ctrl import npcs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   npcs_req_if.sink      req_chan,
   npcs_rsp_if.source    rsp_chan,
   output mem_wr_type    mem_wr,
   output tag_type       rd_issue,
   output rgb_type       query,
   input  scan_res_type  res
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(PALETTE_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PALETTE_ENTRIES - 1);
   localparam logic [ENTRY_W:0] IDX_LIM  = (ENTRY_W + 1)'(PALETTE_ENTRIES);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    addr_ff, addr_in;
   rgb_type             colour_ff, colour_in;
   key_type             best_key_ff, best_key_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic                have_ff, have_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOUR_W-1:0] rsp_idx_ff, rsp_idx_in;

   logic accept;
   logic rsp_take;
   logic better;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_valid_ff && rsp_chan.ready;
   assign better         = !have_ff || (res.key < best_key_ff);

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.colour_index = rsp_idx_ff;

   // Palette write: drop indexes beyond the palette
   assign mem_wr.en       = accept && (req_chan.req_type == REQ_WRITE)
                          && ({1'b0, req_chan.entry_index} < IDX_LIM);
   assign mem_wr.addr     = req_chan.entry_index[IDX_W-1:0];
   assign mem_wr.rgb      = '{r: req_chan.red, g: req_chan.green, b: req_chan.blue};

   // Scan read issue, one entry per cycle
   assign rd_issue.valid = (state_ff == ST_SCAN) && (addr_ff < CNT_END);
   assign rd_issue.last  = (addr_ff == CNT_LAST);
   assign rd_issue.idx   = addr_ff[IDX_W-1:0];

   assign query = colour_ff;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      colour_in    = colour_ff;
      best_key_in  = best_key_ff;
      best_idx_in  = best_idx_ff;
      have_in      = have_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_idx_in   = rsp_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_chan.req_type == REQ_QUERY)) begin
               colour_in = '{r: req_chan.red, g: req_chan.green, b: req_chan.blue};
               addr_in   = '0;
               have_in   = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_issue.valid) begin
               addr_in = addr_ff + CNT_W'(1);
            end
            if (res.tag.valid && better) begin
               best_key_in = res.key;
               best_idx_in = res.tag.idx;
               have_in     = 1'b1;
            end
            if (res.tag.valid && res.tag.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = COLOUR_W'(best_idx_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      colour_ff   <= colour_in;
      best_key_ff <= best_key_in;
      best_idx_ff <= best_idx_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

`ifndef SYNTHESIS
   a_res_in_scan: assert property (@(posedge clock) disable iff (reset)
      res.tag.valid |-> state_ff == ST_SCAN)
      else $error("scan result outside of a scan");

   a_addr_bound: assert property (@(posedge clock) disable iff (reset)
      addr_ff <= CNT_END)
      else $error("scan address counter overran the palette");

   a_last_finish: assert property (@(posedge clock) disable iff (reset)
      res.tag.valid && res.tag.last |=> state_ff == ST_FINISH)
      else $error("last scan result did not finish the query");

   a_finish_has_best: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> have_ff)
      else $error("query finished without any candidate");
`endif

endmodule

/* hdl/nearest_palette_colour_search.sv */
// ----------------------------------------------------------------------------
// nearest_palette_colour_search: nearest palette colour search
// Holds a palette of PALETTE_ENTRIES RGB entries. A write item (req_type 0)
// stores red/green/blue at entry_index and returns nothing; an
// index beyond the palette is dropped. A query item (req_type 1) returns the
// index of the entry with the smallest key, compared in order: primary
// distance, box distance |dr|+|dg|+|db|, entry luminance
// (77R+151G+28B)>>8, then lowest index. The primary distance is the plain
// squared distance when csr metric_mode is 0, or the 77/151/28 weighted
// squared distance shifted right by 5 when it is 1. Every entry must be
// written before the first query. For a query the sequencer reads one
// palette entry per cycle through the single memory read port into the
// three-stage distance unit, and the request channel is held not ready
// until the result is loaded into the output register. A pending result
// does not block further writes. The user must write metric_mode through
// csr_wr_en/csr_wr_data only while no query runs; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module nearest_palette_colour_search import npcs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   npcs_req_if.sink    req_chan,
   npcs_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic           metric_mode_ff, metric_mode_in;
   mem_wr_type     mem_wr;
   tag_type        rd_issue;
   palette_rd_type rd;
   rgb_type        query;
   scan_res_type   res;

   // Metric select register
   assign metric_mode_in = csr_wr_en ? csr_wr_data : metric_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_mode_ff <= METRIC_PLAIN;
      end else begin
         metric_mode_ff <= metric_mode_in;
      end
   end

   // Sequencer: takes items, writes the palette, drives the scan, keeps best
   npcs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .mem_wr   (mem_wr),
      .rd_issue (rd_issue),
      .query    (query),
      .res      (res)
   );

   // Palette memory with registered read
   npcs_palette_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr       (mem_wr),
      .rd_issue (rd_issue),
      .rd       (rd)
   );

   // Shared distance unit, one entry per cycle
   npcs_dist_unit u_dist (
      .clock       (clock),
      .reset       (reset),
      .metric_mode (metric_mode_ff),
      .query       (query),
      .rd          (rd),
      .res         (res)
   );

endmodule
